// ----- hw/rtl/dpd_pkg.sv -----
// Package for the delimiter packet deframer: beat types, register codes, reset values.
`timescale 1ns / 1ps

package dpd_pkg;

  localparam int unsigned MAX_POSTFIX_BYTES_DEF = 8;
  localparam int unsigned LENGTH_BITS_DEF       = 16;

  // pattern register holds at most this many postfix bytes
  localparam int unsigned PATTERN_BYTES = 8;
  localparam int unsigned PATTERN_BITS  = 8 * PATTERN_BYTES;
  localparam int unsigned PLEN_BITS     = 16;
  localparam int unsigned PFX_LEN_BITS  = 4;
  localparam int unsigned MAX_PART_BITS = 16;
  localparam int unsigned CFG_DATA_BITS = 64;

  localparam logic [PATTERN_BITS-1:0]  PATTERN_RST  = 64'h0000_0000_0000_0A0D;
  localparam logic [PFX_LEN_BITS-1:0]  PFX_LEN_RST  = 4'd2;
  localparam logic [MAX_PART_BITS-1:0] MAX_PART_RST = 16'd1024;
  localparam logic                     GROW_RST     = 1'b0;

  typedef enum logic [1:0] {
    CFG_POSTFIX_PATTERN   = 2'd0,
    CFG_POSTFIX_LENGTH    = 2'd1,
    CFG_MAX_PARTIAL_BYTES = 2'd2,
    CFG_AUTO_GROW         = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [PATTERN_BITS-1:0]  postfix_pattern;
    logic [PFX_LEN_BITS-1:0]  postfix_length;
    logic [MAX_PART_BITS-1:0] max_partial_bytes;
    logic                     auto_grow;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] client_tag;
    logic [7:0]  instance_tag;
  } in_item_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 byte_valid;
    logic                 packet_end;
    logic [PLEN_BITS-1:0] packet_length;
    logic [15:0]          client_tag_out;
    logic [7:0]           instance_tag_out;
    logic                 overflow_error;
  } out_item_t;

endpackage

// ----- hw/rtl/delimiter_packet_deframer.sv -----
// Top level of the delimiter packet deframer: handshakes, registers and window state.
`timescale 1ns / 1ps

// Splits a byte stream into packets closed by a postfix of 1 to 8 bytes (reset: CR LF).
// One byte beat is accepted every clock unless an output stall holds it. Each byte is
// caught in the input register; its result register is loaded when the step advances.
// The window compare against the postfix is done in parallel as combinational logic, and
// the window, fill and length registers close their loop through it, which is what sets
// the one-byte-per-clock rate. A beat yields a result only when a byte leaves the window,
// a packet ends, or a byte is dropped for size; the postfix bytes themselves are never
// passed on. Write configuration only while no bytes are in flight.

module delimiter_packet_deframer #(
  parameter int unsigned MAX_POSTFIX_BYTES = dpd_pkg::MAX_POSTFIX_BYTES_DEF,
  parameter int unsigned LENGTH_BITS       = dpd_pkg::LENGTH_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  dpd_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output dpd_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  dpd_pkg::cfg_idx_t                    cfg_index,
  input  logic [dpd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  import dpd_pkg::*;

  localparam int unsigned CAP =
    (MAX_POSTFIX_BYTES > PATTERN_BYTES) ? PATTERN_BYTES : MAX_POSTFIX_BYTES;
  localparam int unsigned FILL_BITS = $clog2(CAP + 1);

  cfg_t                   cfg_r;
  in_item_t               in_r;
  logic                   in_valid_r;
  out_item_t              out_r;
  logic                   out_valid_r;
  logic [CAP-1:0][7:0]    win_r, win_nxt;
  logic [FILL_BITS-1:0]   fill_r, fill_nxt;
  logic [LENGTH_BITS-1:0] emitted_r, emitted_nxt;
  out_item_t              res;
  logic                   res_valid;
  logic                   advance, in_take;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.postfix_pattern   <= PATTERN_RST;
      cfg_r.postfix_length    <= PFX_LEN_RST;
      cfg_r.max_partial_bytes <= MAX_PART_RST;
      cfg_r.auto_grow         <= GROW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POSTFIX_PATTERN:   cfg_r.postfix_pattern   <= cfg_data[PATTERN_BITS-1:0];
        CFG_POSTFIX_LENGTH:    cfg_r.postfix_length    <= cfg_data[PFX_LEN_BITS-1:0];
        CFG_MAX_PARTIAL_BYTES: cfg_r.max_partial_bytes <= cfg_data[MAX_PART_BITS-1:0];
        CFG_AUTO_GROW:         cfg_r.auto_grow         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dpd_step #(
    .MAX_POSTFIX_BYTES (MAX_POSTFIX_BYTES),
    .LENGTH_BITS       (LENGTH_BITS)
  ) u_step (
    .cfg          (cfg_r),
    .item         (in_r),
    .win_r        (win_r),
    .fill_r       (fill_r),
    .emitted_r    (emitted_r),
    .win_nxt      (win_nxt),
    .fill_nxt     (fill_nxt),
    .emitted_nxt  (emitted_nxt),
    .result       (res),
    .result_valid (res_valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      win_r       <= '0;
      fill_r      <= '0;
      emitted_r   <= '0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= res_valid;
        win_r       <= win_nxt;
        fill_r      <= fill_nxt;
        emitted_r   <= emitted_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

endmodule

// ----- hw/rtl/dpd_step.sv -----
// Per-byte step of the deframer: window trim, size check, release, insert and postfix match.
`timescale 1ns / 1ps

module dpd_step #(
  parameter int unsigned MAX_POSTFIX_BYTES = dpd_pkg::MAX_POSTFIX_BYTES_DEF,
  parameter int unsigned LENGTH_BITS       = dpd_pkg::LENGTH_BITS_DEF,
  localparam int unsigned CAP =
    (MAX_POSTFIX_BYTES > dpd_pkg::PATTERN_BYTES) ? dpd_pkg::PATTERN_BYTES : MAX_POSTFIX_BYTES,
  localparam int unsigned FILL_BITS = $clog2(CAP + 1)
) (
  input  dpd_pkg::cfg_t                 cfg,
  input  dpd_pkg::in_item_t             item,
  input  logic [CAP-1:0][7:0]           win_r,
  input  logic [FILL_BITS-1:0]          fill_r,
  input  logic [LENGTH_BITS-1:0]        emitted_r,
  output logic [CAP-1:0][7:0]           win_nxt,
  output logic [FILL_BITS-1:0]          fill_nxt,
  output logic [LENGTH_BITS-1:0]        emitted_nxt,
  output dpd_pkg::out_item_t            result,
  output logic                          result_valid
);

  import dpd_pkg::*;

  localparam int unsigned SUM_BITS = ((LENGTH_BITS > MAX_PART_BITS) ?
                                      LENGTH_BITS : MAX_PART_BITS) + 1;
  localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

  logic [PFX_LEN_BITS-1:0] len4;
  logic [FILL_BITS-1:0]    len, drop, fill_t, fill_a, fill_n;
  logic [CAP-1:0][7:0]     win_t, win_a, win_n, pat;
  logic [SUM_BITS-1:0]     pending, plen_ext;
  logic [LENGTH_BITS-1:0]  cnt_a;
  logic                    ovf, rel, hit, take;

  always_comb begin
    // effective postfix length, clamped to 1..CAP
    len4 = cfg.postfix_length;
    if (len4 == '0) begin
      len4 = PFX_LEN_BITS'(1);
    end
    if (len4 > PFX_LEN_BITS'(CAP)) begin
      len4 = PFX_LEN_BITS'(CAP);
    end
    len = FILL_BITS'(len4);

    for (int i = 0; i < CAP; i++) begin
      pat[i] = cfg.postfix_pattern[8*i +: 8];
    end

    // drop oldest bytes beyond a shortened postfix
    drop   = '0;
    win_t  = win_r;
    fill_t = fill_r;
    if (fill_r > len) begin
      drop   = fill_r - len;
      win_t  = win_r >> {drop, 3'b000};
      fill_t = len;
      for (int i = 0; i < CAP; i++) begin
        if (FILL_BITS'(i) >= len) begin
          win_t[i] = '0;
        end
      end
    end

    pending = SUM_BITS'(emitted_r) + SUM_BITS'(fill_t) + SUM_BITS'(1);
    ovf     = !cfg.auto_grow && (pending > SUM_BITS'(cfg.max_partial_bytes));

    // release oldest byte of a full window
    rel    = (fill_t == len);
    win_a  = win_t;
    fill_a = fill_t;
    cnt_a  = emitted_r;
    if (rel) begin
      win_a  = win_t >> 8;
      fill_a = fill_t - FILL_BITS'(1);
      if (emitted_r != CNT_MAX) begin
        cnt_a = emitted_r + LENGTH_BITS'(1);
      end
    end

    for (int i = 0; i < CAP; i++) begin
      win_n[i] = (FILL_BITS'(i) == fill_a) ? item.data_byte : win_a[i];
    end
    fill_n = fill_a + FILL_BITS'(1);

    hit = (fill_n == len);
    for (int i = 0; i < CAP; i++) begin
      if (FILL_BITS'(i) < len && win_n[i] != pat[i]) begin
        hit = 1'b0;
      end
    end

    take     = !ovf;
    plen_ext = SUM_BITS'(cnt_a);

    if (!take) begin
      win_nxt     = win_t;
      fill_nxt    = fill_t;
      emitted_nxt = emitted_r;
    end else if (hit) begin
      win_nxt     = '0;
      fill_nxt    = '0;
      emitted_nxt = '0;
    end else begin
      win_nxt     = win_n;
      fill_nxt    = fill_n;
      emitted_nxt = cnt_a;
    end

    result.out_byte         = (take && rel) ? win_t[0] : 8'd0;
    result.byte_valid       = take && rel;
    result.packet_end       = take && hit;
    result.packet_length    = (take && hit) ? plen_ext[PLEN_BITS-1:0] : '0;
    result.client_tag_out   = item.client_tag;
    result.instance_tag_out = item.instance_tag;
    result.overflow_error   = ovf;
    result_valid = ovf || result.byte_valid || result.packet_end;
  end

endmodule
